>>> src/rfp_pkg.sv
package rfp_pkg;

    // frame layout: start byte at position 0, end byte at position 13
    localparam logic [3:0] LAST_POS  = 4'd13;
    localparam logic [3:0] CHECK_POS = 4'd11;
    localparam logic [3:0] TAG_POS   = 4'd3;

    // reset values of the configuration registers
    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
    localparam logic [7:0]  START_RESET   = 8'h02;
    localparam logic [7:0]  END_RESET     = 8'h03;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TIMEOUT = 2'd0,
        CFG_START   = 2'd1,
        CFG_END     = 2'd2
    } cfg_index_t;

    // item kinds
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_POLL = 1'b1
    } op_t;

    // poll event codes
    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_NEW     = 2'd1,
        EV_REMOVED = 2'd2
    } event_t;

    // per-item outcome of the frame parser
    typedef struct packed {
        logic        done;
        logic        ok;
        logic [31:0] tag;
    } frame_res_t;

    // ascii hex digit decode: bit 4 set when the byte is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                d = c - 8'h30;
                hex_value = {1'b0, d[3:0]};
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                d = c - 8'h37;
                hex_value = {1'b0, d[3:0]};
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                d = c - 8'h57;
                hex_value = {1'b0, d[3:0]};
            end
            else
            begin
                hex_value = 5'h10;
            end
        end
    endfunction

endpackage

>>> src/rfp_frame.sv
module rfp_frame
    import rfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic       op,
    input  logic [7:0] rx_byte,
    input  logic [7:0] start_byte,
    input  logic [7:0] end_byte,
    output frame_res_t res
);

    logic [3:0]  byte_count_reg, byte_count_next;
    logic [7:0]  version_acc_reg, version_acc_next;
    logic [31:0] tag_acc_reg, tag_acc_next;
    logic [7:0]  check_acc_reg, check_acc_next;
    logic        digit_error_reg, digit_error_next;

    logic [4:0]  hv;
    logic [3:0]  nib;
    logic [7:0]  xsum;

    assign hv   = hex_value(rx_byte);
    assign nib  = hv[4] ? 4'd0 : hv[3:0];
    assign xsum = version_acc_reg ^ check_acc_reg ^ tag_acc_reg[7:0] ^ tag_acc_reg[15:8]
                ^ tag_acc_reg[23:16] ^ tag_acc_reg[31:24];

    // frame assembly for one byte
    always_comb
    begin
        byte_count_next  = byte_count_reg;
        version_acc_next = version_acc_reg;
        tag_acc_next     = tag_acc_reg;
        check_acc_next   = check_acc_reg;
        digit_error_next = digit_error_reg;
        res.done = 1'b0;
        res.ok   = 1'b0;
        res.tag  = 32'd0;
        if (op == OP_BYTE)
        begin
            if (rx_byte == start_byte)
            begin
                version_acc_next = 8'd0;
                tag_acc_next     = 32'd0;
                check_acc_next   = 8'd0;
                digit_error_next = 1'b0;
                byte_count_next  = 4'd1;
            end
            else if (byte_count_reg == 4'd0)
            begin
                // hunting, byte ignored
            end
            else if (byte_count_reg == LAST_POS)
            begin
                byte_count_next = 4'd0;
                if (rx_byte == end_byte)
                begin
                    res.done = 1'b1;
                    res.ok   = !digit_error_reg && (xsum == 8'd0);
                    res.tag  = res.ok ? tag_acc_reg : 32'd0;
                end
            end
            else if (rx_byte == end_byte)
            begin
                byte_count_next = 4'd0;
            end
            else
            begin
                if (hv[4])
                    digit_error_next = 1'b1;
                if (byte_count_reg < TAG_POS)
                    version_acc_next = {version_acc_reg[3:0], nib};
                else if (byte_count_reg < CHECK_POS)
                    tag_acc_next = {tag_acc_reg[27:0], nib};
                else
                    check_acc_next = {check_acc_reg[3:0], nib};
                byte_count_next = byte_count_reg + 4'd1;
            end
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= 4'd0;
            version_acc_reg <= 8'd0;
            tag_acc_reg     <= 32'd0;
            check_acc_reg   <= 8'd0;
            digit_error_reg <= 1'b0;
        end
        else if (fire)
        begin
            byte_count_reg  <= byte_count_next;
            version_acc_reg <= version_acc_next;
            tag_acc_reg     <= tag_acc_next;
            check_acc_reg   <= check_acc_next;
            digit_error_reg <= digit_error_next;
        end
    end

endmodule

>>> src/rfid_frame_parser_with_presence_unit.sv
// Reader frame parser with tag presence tracking.
// Input channel (in_valid / in_stall): op 0 carries one received serial byte in
// rx_byte, op 1 is a periodic poll carrying the current time in now_ms.
// Output channel (out_valid / out_stall): exactly one result per input item, in
// order. Byte items report frame_done / frame_ok when they close a frame; polls
// report a new tag or a tag removal in event_res / event_tag. held_tag_out is
// the tag held after the item, 0 when none.
// Configuration (cfg_we / cfg_index / cfg_data): 0 timeout in ms, 1 start byte,
// 2 end byte; write only while no items are in flight.
// Each item passes through the input register, then the parse and presence
// logic into the result register, where out_valid presents it.
// Throughput is one item per cycle while the receiver does not stall, set by
// the state update that parser and presence state make for each item.
// Reset clears the parser, the presence state and both pipeline registers, and
// loads the configuration defaults (1000 ms, start 0x02, end 0x03).
// When the receiver stalls, the result register holds its payload, the input
// register keeps one more item, and in_stall rises only when both are full.
module rfid_frame_parser_with_presence_unit
    import rfp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   op,
    input  logic [7:0]             rx_byte,
    input  logic [31:0]            now_ms,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   frame_done,
    output logic                   frame_ok,
    output logic [1:0]             event_res,
    output logic [31:0]            event_tag,
    output logic [31:0]            held_tag_out,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [31:0] timeout_reg;
    logic [7:0]  start_reg;
    logic [7:0]  end_reg;

    logic        s1_valid_reg;
    logic        s1_op_reg;
    logic [7:0]  s1_byte_reg;
    logic [31:0] s1_now_reg;

    logic        out_valid_reg;
    logic        done_reg;
    logic        ok_reg;
    logic [1:0]  event_reg;
    logic [31:0] event_tag_reg;
    logic [31:0] held_out_reg;

    logic [31:0] pending_tag_reg, pending_tag_next;
    logic [31:0] held_tag_reg, held_tag_next;
    logic [31:0] announced_reg, announced_next;
    logic [31:0] last_seen_reg, last_seen_next;
    logic [1:0]  event_next;
    logic [31:0] event_tag_next;
    logic [31:0] elapsed;

    logic        out_free;
    logic        fire;
    frame_res_t  fres;

    // pipeline flow control
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            start_reg   <= START_RESET;
            end_reg     <= END_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_TIMEOUT: timeout_reg <= cfg_data;
                CFG_START:   start_reg   <= cfg_data[7:0];
                CFG_END:     end_reg     <= cfg_data[7:0];
                default:     ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_op_reg    <= 1'b0;
            s1_byte_reg  <= 8'd0;
            s1_now_reg   <= 32'd0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
            if (in_valid)
            begin
                s1_op_reg   <= op;
                s1_byte_reg <= rx_byte;
                s1_now_reg  <= now_ms;
            end
        end
    end

    rfp_frame u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .op         (s1_op_reg),
        .rx_byte    (s1_byte_reg),
        .start_byte (start_reg),
        .end_byte   (end_reg),
        .res        (fres)
    );

    assign elapsed = s1_now_reg - last_seen_reg;

    // presence tracking
    always_comb
    begin
        pending_tag_next = pending_tag_reg;
        held_tag_next    = held_tag_reg;
        announced_next   = announced_reg;
        last_seen_next   = last_seen_reg;
        event_next       = EV_NONE;
        event_tag_next   = 32'd0;
        if (s1_op_reg == OP_BYTE)
        begin
            if (fres.done)
                pending_tag_next = fres.tag;
        end
        else
        begin
            pending_tag_next = 32'd0;
            if (pending_tag_reg != 32'd0)
            begin
                held_tag_next  = pending_tag_reg;
                last_seen_next = s1_now_reg;
                if (announced_reg != pending_tag_reg)
                begin
                    announced_next = pending_tag_reg;
                    event_next     = EV_NEW;
                    event_tag_next = pending_tag_reg;
                end
            end
            else if (held_tag_reg != 32'd0 && elapsed >= timeout_reg)
            begin
                held_tag_next  = 32'd0;
                announced_next = 32'd0;
                event_next     = EV_REMOVED;
            end
        end
    end

    // presence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_tag_reg <= 32'd0;
            held_tag_reg    <= 32'd0;
            announced_reg   <= 32'd0;
            last_seen_reg   <= 32'd0;
        end
        else if (fire)
        begin
            pending_tag_reg <= pending_tag_next;
            held_tag_reg    <= held_tag_next;
            announced_reg   <= announced_next;
            last_seen_reg   <= last_seen_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            ok_reg        <= 1'b0;
            event_reg     <= EV_NONE;
            event_tag_reg <= 32'd0;
            held_out_reg  <= 32'd0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                done_reg      <= fres.done;
                ok_reg        <= fres.ok;
                event_reg     <= event_next;
                event_tag_reg <= event_tag_next;
                held_out_reg  <= held_tag_next;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_done   = done_reg;
    assign frame_ok     = ok_reg;
    assign event_res    = event_reg;
    assign event_tag    = event_tag_reg;
    assign held_tag_out = held_out_reg;

endmodule
